[hw/rtl/fcsg_pkg.sv]
// Shared constants and types for the filled circle span generator.
// No dependencies; imported by filled_circle_span_generator.
`timescale 1ns / 1ps

package fcsg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int COORD_BITS = 12;

  localparam int CFG_W   = 13;
  localparam int CRD_W   = 14;
  localparam int RAD_W   = 5;
  localparam int COL_W   = 32;
  localparam int SPAN_W  = 12;
  localparam int IN_W    = 72;  // 65 bits of fields, padded to bytes
  localparam int OUT_W   = 72;  // 68 bits of fields, padded to bytes
  localparam int IDX_W   = 1;

  // wide enough for center +/- radius and the screen limits, signed
  localparam int WRK_W   = 16;
  localparam int BAL_W   = 9;

  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // screen registers above 2^COORD_BITS are treated as 2^COORD_BITS
  localparam logic [CFG_W:0] SCREEN_LIM =
    (COORD_BITS >= CFG_W) ? {1'b0, {CFG_W{1'b1}}} : (CFG_W+1)'(1 << COORD_BITS);

  localparam logic [RAD_W-1:0] RAD_LIM = RAD_W'(MAX_RADIUS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  // candidate span within one walk step
  typedef enum logic [1:0] {
    PH_YPOS = 2'd0,
    PH_YNEG = 2'd1,
    PH_XPOS = 2'd2,
    PH_XNEG = 2'd3
  } phase_t;

endpackage

[hw/rtl/filled_circle_span_generator.sv]
// Filled disk span generator: midpoint circle walk, span clipping, output register.
// Depends on fcsg_pkg.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one disk command per transfer. tdata = center_x, center_y, radius,
//           fill_color. in_tready is high only while the block is idle.
//   out_* : one clipped horizontal span per transfer; tuser = span_valid,
//           tlast marks the final span of the command. An invisible or
//           zero-radius disk yields a single transfer with tuser = 0, tlast = 1.
//   cfg_* : register writes (0 = screen_width, 1 = screen_height), always ready;
//           write only while no command is in flight.
// Sequence: the command is taken in idle and its bounding box is tested in
//   the check state; each midpoint step then sends four candidate spans
//   through the shared clip unit, one per phase, and the flush state releases
//   the held last span. The clip unit takes a single candidate per cycle while
//   the output is not stalled. The final span is held back one visible span
//   so that tlast can be set on it.
// Stall: while an output transfer waits on out_tready the walk pauses.
// Reset: rst_n (synchronous) returns to idle and loads 640 x 480.
module filled_circle_span_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [13:0] center_x, [27:14] center_y, [32:28] radius, [64:33] fill_color
  input  logic [fcsg_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [11:0] span_left, [23:12] span_right, [35:24] span_row, [67:36] span_color
  output logic [fcsg_pkg::OUT_W-1:0]     out_tdata,
  // [0] span_valid
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcsg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fcsg_pkg::CFG_W-1:0]     cfg_data
);
  import fcsg_pkg::*;

  state_t                    state_r, state_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [CFG_W-1:0]          scr_w_cfg_r, scr_h_cfg_r;
  logic signed [WRK_W-1:0]   cx_r, cy_r;
  logic [RAD_W-1:0]          rad_r;
  logic [COL_W-1:0]          color_r;
  logic [RAD_W-1:0]          xoff_r, xoff_nxt, yoff_r, yoff_nxt;
  logic signed [BAL_W-1:0]   bal_r, bal_nxt;
  logic                      newy_r, newy_nxt;

  logic                      pend_v_r, pend_v_nxt;
  logic [SPAN_W-1:0]         pend_l_r, pend_l_nxt, pend_rt_r, pend_rt_nxt;
  logic [SPAN_W-1:0]         pend_row_r, pend_row_nxt;

  logic                      out_v_r, out_v_nxt, out_user_r, out_user_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [SPAN_W-1:0]         out_l_r, out_l_nxt, out_rt_r, out_rt_nxt;
  logic [SPAN_W-1:0]         out_row_r, out_row_nxt;
  logic [COL_W-1:0]          out_col_r, out_col_nxt;

  logic [CFG_W:0]            scr_w, scr_h;
  logic signed [WRK_W-1:0]   w_s, h_s, r_s;
  logic                      can_go, reject;

  // shared clip unit signals
  logic [RAD_W-1:0]          half, dmag;
  logic signed [WRK_W-1:0]   x1, x2, row, x1c, x2c;
  logic                      cand_en, vis;

  // step update
  logic signed [BAL_W-1:0]   bal_a;
  logic [RAD_W:0]            xnext;
  logic [RAD_W-1:0]          in_rad;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_W-68)'(0), out_col_r, out_row_r, out_rt_r, out_l_r};

  assign scr_w = ({1'b0, scr_w_cfg_r} > SCREEN_LIM) ? SCREEN_LIM : {1'b0, scr_w_cfg_r};
  assign scr_h = ({1'b0, scr_h_cfg_r} > SCREEN_LIM) ? SCREEN_LIM : {1'b0, scr_h_cfg_r};
  assign w_s   = signed'(WRK_W'(scr_w));
  assign h_s   = signed'(WRK_W'(scr_h));
  assign r_s   = signed'(WRK_W'(rad_r));

  assign in_rad = (in_tdata[32:28] > RAD_LIM) ? RAD_LIM : in_tdata[32:28];

  assign can_go = !out_v_r || out_tready;

  assign reject = (rad_r == '0) || (cx_r - r_s >= w_s) || (cx_r + r_s < 0) ||
                  (cy_r - r_s >= h_s) || (cy_r + r_s < 0) || (r_s > w_s);

  // candidate selection for the current phase
  always_comb begin
    half    = xoff_r;
    dmag    = yoff_r;
    cand_en = 1'b0;
    case (phase_r)
      PH_YPOS: begin
        cand_en = newy_r;
      end
      PH_YNEG: begin
        cand_en = newy_r;
      end
      PH_XPOS: begin
        half    = yoff_r;
        dmag    = xoff_r;
        cand_en = (xoff_r != yoff_r);
      end
      PH_XNEG: begin
        half    = yoff_r;
        dmag    = xoff_r;
        cand_en = (xoff_r != yoff_r) && (xoff_r != '0);
      end
      default: begin
        cand_en = 1'b0;
      end
    endcase
  end

  assign x1  = cx_r - signed'(WRK_W'(half));
  assign x2  = cx_r + signed'(WRK_W'(half));
  assign row = (phase_r == PH_YNEG || phase_r == PH_XNEG) ?
               cy_r - signed'(WRK_W'(dmag)) : cy_r + signed'(WRK_W'(dmag));
  assign x1c = (x1 < 0) ? '0 : x1;
  assign x2c = (x2 > w_s - WRK_W'(1)) ? w_s - WRK_W'(1) : x2;
  assign vis = cand_en && (row >= 0) && (row < h_s) && (x1c < w_s) && (x2c >= 0);

  // midpoint step
  assign bal_a = bal_r + signed'({(BAL_W-RAD_W-1)'(0), xoff_r, 1'b1});
  assign xnext = {1'b0, xoff_r} + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    xoff_nxt     = xoff_r;
    yoff_nxt     = yoff_r;
    bal_nxt      = bal_r;
    newy_nxt     = newy_r;
    pend_v_nxt   = pend_v_r;
    pend_l_nxt   = pend_l_r;
    pend_rt_nxt  = pend_rt_r;
    pend_row_nxt = pend_row_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    out_l_nxt    = out_l_r;
    out_rt_nxt   = out_rt_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          pend_v_nxt = 1'b0;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        phase_nxt = PH_YPOS;
        xoff_nxt  = '0;
        yoff_nxt  = rad_r;
        bal_nxt   = -signed'(BAL_W'(rad_r));
        newy_nxt  = 1'b1;
        state_nxt = reject ? ST_FLUSH : ST_WALK;
      end
      ST_WALK: begin
        if (can_go) begin
          if (vis) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_user_nxt = 1'b1;
              out_last_nxt = 1'b0;
              out_l_nxt    = pend_l_r;
              out_rt_nxt   = pend_rt_r;
              out_row_nxt  = pend_row_r;
              out_col_nxt  = color_r;
            end
            pend_v_nxt   = 1'b1;
            pend_l_nxt   = x1c[SPAN_W-1:0];
            pend_rt_nxt  = x2c[SPAN_W-1:0];
            pend_row_nxt = row[SPAN_W-1:0];
          end
          phase_nxt = phase_t'(phase_r + 2'd1);
          if (phase_r == PH_XNEG) begin
            xoff_nxt = xnext[RAD_W-1:0];
            if (bal_a >= 0) begin
              yoff_nxt = yoff_r - 1'b1;
              bal_nxt  = bal_a - signed'({(BAL_W-RAD_W-1)'(0), yoff_r - 1'b1, 1'b0});
              newy_nxt = 1'b1;
              if (xnext > {1'b0, yoff_r - 1'b1}) state_nxt = ST_FLUSH;
            end else begin
              bal_nxt  = bal_a;
              newy_nxt = 1'b0;
              if (xnext > {1'b0, yoff_r}) state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_go) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          out_user_nxt = pend_v_r;
          if (pend_v_r) begin
            out_l_nxt   = pend_l_r;
            out_rt_nxt  = pend_rt_r;
            out_row_nxt = pend_row_r;
            out_col_nxt = color_r;
          end else begin
            out_l_nxt   = '0;
            out_rt_nxt  = '0;
            out_row_nxt = '0;
            out_col_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
      scr_w_cfg_r <= SCREEN_WIDTH_RST;
      scr_h_cfg_r <= SCREEN_HEIGHT_RST;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w_cfg_r <= cfg_data;
          REG_SCREEN_HEIGHT: scr_h_cfg_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cx_r    <= signed'({{(WRK_W-CRD_W){in_tdata[13]}}, in_tdata[13:0]});
      cy_r    <= signed'({{(WRK_W-CRD_W){in_tdata[27]}}, in_tdata[27:14]});
      rad_r   <= in_rad;
      color_r <= in_tdata[64:33];
    end
    phase_r    <= phase_nxt;
    xoff_r     <= xoff_nxt;
    yoff_r     <= yoff_nxt;
    bal_r      <= bal_nxt;
    newy_r     <= newy_nxt;
    pend_l_r   <= pend_l_nxt;
    pend_rt_r  <= pend_rt_nxt;
    pend_row_r <= pend_row_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
    out_l_r    <= out_l_nxt;
    out_rt_r   <= out_rt_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

endmodule
